@@ rtl/core/hsv2rgb_pkg.sv @@
// Shared widths, constants and the hue sector type of the HSV to RGB duty converter.
package hsv2rgb_pkg;

   localparam int HUE_W  = 9;
   localparam int PCT_W  = 7;
   localparam int CHAN_W = 8;

   localparam int DUTY_FULL_DEFAULT = 255;

   localparam int PCT_MAX     = 100;
   localparam int SECTOR_DEG  = 60;
   localparam int SECTOR_NUM  = 6;
   localparam int FRAC_SCALE  = PCT_MAX * SECTOR_DEG;
   localparam int HUE_STEPS   = ((1 << HUE_W) - 1) / SECTOR_DEG;
   localparam int STEP_W      = $clog2(HUE_STEPS + 1);
   localparam int REM_W       = $clog2(SECTOR_DEG);

   // Every channel is x * v * DUTY_FULL / DIV_CONST with x at most FRAC_SCALE.
   localparam int X_W        = $clog2(FRAC_SCALE + 1);
   localparam int M_W        = X_W + PCT_W;
   localparam longint unsigned DIV_CONST = 64'(FRAC_SCALE) * 64'(PCT_MAX);
   localparam int CHAN_MAX   = (1 << CHAN_W) - 1;

   // Dividends below SAT_LIMIT give a quotient that fits a channel.
   localparam longint unsigned SAT_LIMIT = 64'(CHAN_MAX + 1) * DIV_CONST;
   localparam int Q_W        = $clog2(SAT_LIMIT);
   localparam int DIV_LOG    = $clog2(DIV_CONST);
   localparam int RECIP_SHIFT = Q_W + DIV_LOG;
   localparam longint unsigned RECIP_MULT =
      ((64'd1 << RECIP_SHIFT) + DIV_CONST - 64'd1) / DIV_CONST;
   localparam int RECIP_W    = $clog2(RECIP_MULT + 1);

   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

endpackage

@@ rtl/core/hsv2rgb_req_if.sv @@
// Request channel carrying one HSV colour.
interface hsv2rgb_req_if
   import hsv2rgb_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [HUE_W-1:0]  hue;
   logic [PCT_W-1:0]  saturation;
   logic [PCT_W-1:0]  brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

@@ rtl/core/hsv2rgb_rsp_if.sv @@
// Result channel carrying one set of RGB duty values.
interface hsv2rgb_rsp_if
   import hsv2rgb_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/core/hsv_to_rgb_percent_top.sv @@
// HSV to RGB duty converter, seven-stage pipeline.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The depth is set by the two multiplies and the reciprocal divide in each channel lane.
// Reset (synchronous) clears all stage valid bits; data registers are not reset.
module hsv_to_rgb_percent_top
   import hsv2rgb_pkg::*;
#(
   parameter int DUTY_FULL = DUTY_FULL_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   hsv2rgb_req_if.sink   req,
   hsv2rgb_rsp_if.source rsp
);
   localparam int STAGES  = 7;
   localparam int LANE_D  = 4;

   logic                 enable;
   logic [STAGES-1:0]    valid_ff, valid_in;

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [PCT_W-1:0]     s_ff, s_in;
   logic [PCT_W-1:0]     v1_ff, v1_in;
   sector_type           sec1_ff, sec1_in;

   logic [X_W-1:0]       xv_ff, xp_ff, xq_ff, xt_ff;
   logic [X_W-1:0]       xv_in, xp_in, xq_in, xt_in;
   logic [PCT_W-1:0]     v2_ff;
   sector_type           sec2_ff;

   sector_type           sec_pipe_ff [LANE_D];
   logic [CHAN_W-1:0]    dv, dp, dq, dt;

   logic [CHAN_W-1:0]    red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0]    red_in, green_in, blue_in;

   assign enable    = !valid_ff[STAGES-1] || rsp.ready;
   assign req.ready = enable;
   assign valid_in  = {valid_ff[STAGES-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: clamp the percent inputs and split the hue into sector and remainder.
   always_comb begin
      logic [STEP_W-1:0] k;
      logic [STEP_W-1:0] sec;
      k = '0;
      for (int i = 1; i <= HUE_STEPS; i++) begin
         if (req.hue >= HUE_W'(i * SECTOR_DEG)) begin
            k = k + STEP_W'(1);
         end
      end
      rem_in  = REM_W'(req.hue - HUE_W'(HUE_W'(k) * HUE_W'(SECTOR_DEG)));
      sec     = (k >= STEP_W'(SECTOR_NUM)) ? k - STEP_W'(SECTOR_NUM) : k;
      sec1_in = sector_type'(sec[2:0]);
      s_in    = (req.saturation > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : req.saturation;
      v1_in   = (req.brightness > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : req.brightness;
   end

   // Stage 2: the four numerators, all over a common denominator of sixtieths of percent.
   assign xv_in = X_W'(FRAC_SCALE);
   assign xp_in = X_W'(PCT_W'(PCT_MAX) - s_ff) * X_W'(SECTOR_DEG);
   assign xq_in = X_W'(FRAC_SCALE) - X_W'(rem_ff) * X_W'(s_ff);
   assign xt_in = X_W'(FRAC_SCALE) - X_W'(REM_W'(SECTOR_DEG) - rem_ff) * X_W'(s_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         s_ff    <= s_in;
         v1_ff   <= v1_in;
         sec1_ff <= sec1_in;
         xv_ff   <= xv_in;
         xp_ff   <= xp_in;
         xq_ff   <= xq_in;
         xt_ff   <= xt_in;
         v2_ff   <= v1_ff;
         sec2_ff <= sec1_ff;
         sec_pipe_ff[0] <= sec2_ff;
         for (int i = 1; i < LANE_D; i++) begin
            sec_pipe_ff[i] <= sec_pipe_ff[i-1];
         end
      end
   end

   hsv2rgb_lane #(.DUTY_FULL(DUTY_FULL)) u_lane_v (
      .clock(clock), .enable(enable), .x(xv_ff), .v(v2_ff), .duty(dv)
   );
   hsv2rgb_lane #(.DUTY_FULL(DUTY_FULL)) u_lane_p (
      .clock(clock), .enable(enable), .x(xp_ff), .v(v2_ff), .duty(dp)
   );
   hsv2rgb_lane #(.DUTY_FULL(DUTY_FULL)) u_lane_q (
      .clock(clock), .enable(enable), .x(xq_ff), .v(v2_ff), .duty(dq)
   );
   hsv2rgb_lane #(.DUTY_FULL(DUTY_FULL)) u_lane_t (
      .clock(clock), .enable(enable), .x(xt_ff), .v(v2_ff), .duty(dt)
   );

   always_comb begin
      unique case (sec_pipe_ff[LANE_D-1])
         SEC_RED:    begin red_in = dv; green_in = dt; blue_in = dp; end
         SEC_YELLOW: begin red_in = dq; green_in = dv; blue_in = dp; end
         SEC_GREEN:  begin red_in = dp; green_in = dv; blue_in = dt; end
         SEC_CYAN:   begin red_in = dp; green_in = dq; blue_in = dv; end
         SEC_BLUE:   begin red_in = dt; green_in = dp; blue_in = dv; end
         default:    begin red_in = dv; green_in = dp; blue_in = dq; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp.valid = valid_ff[STAGES-1];
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;
endmodule

@@ rtl/core/hsv2rgb_lane.sv @@
// Four-stage scaling lane: duty = min(floor(x * v * DUTY_FULL / DIV_CONST), CHAN_MAX).
module hsv2rgb_lane
   import hsv2rgb_pkg::*;
#(
   parameter int DUTY_FULL = DUTY_FULL_DEFAULT
) (
   input  logic              clock,
   input  logic              enable,
   input  logic [X_W-1:0]    x,
   input  logic [PCT_W-1:0]  v,
   output logic [CHAN_W-1:0] duty
);
   localparam int DUTY_W = $clog2(DUTY_FULL + 1);
   localparam int N_W    = (M_W + DUTY_W > Q_W) ? M_W + DUTY_W : Q_W;
   localparam int P_W    = Q_W + RECIP_W;
   localparam logic [N_W-1:0]     DUTY_N  = N_W'(DUTY_FULL);
   localparam logic [N_W-1:0]     SAT_N   = N_W'(SAT_LIMIT);
   localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP_MULT);

   logic [M_W-1:0]    m_ff, m_in;
   logic [N_W-1:0]    n_ff, n_in;
   logic              sat_ff, sat_in;
   logic [P_W-1:0]    prod_ff, prod_in;
   logic [CHAN_W-1:0] duty_ff, duty_in;

   assign m_in    = M_W'(x) * M_W'(v);
   assign n_in    = N_W'(m_ff) * DUTY_N;
   assign sat_in  = (n_ff >= SAT_N);
   // Reciprocal multiply; exact for every dividend below the saturation limit.
   assign prod_in = P_W'(n_ff[Q_W-1:0]) * P_W'(RECIP_C);
   assign duty_in = sat_ff ? CHAN_W'(CHAN_MAX) : prod_ff[RECIP_SHIFT +: CHAN_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         m_ff    <= m_in;
         n_ff    <= n_in;
         sat_ff  <= sat_in;
         prod_ff <= prod_in;
         duty_ff <= duty_in;
      end
   end

   assign duty = duty_ff;
endmodule

@@ rtl/core/hsv2rgb_checker.sv @@
// Port-level assertions for the HSV to RGB converter and their bind to the top level.
module hsv2rgb_checker
   import hsv2rgb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAN_W-1:0] rsp_red,
   input logic [CHAN_W-1:0] rsp_green,
   input logic [CHAN_W-1:0] rsp_blue
);
   // Reset empties the pipeline, so no result is offered right after it.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // With no result waiting the pipeline can always move, so a request is never refused.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused while the output is empty");

   // A taken result lets the pipeline move in the same cycle.
   a_ready_on_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |-> req_ready)
      else $error("request refused while a result is taken");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue)))
      else $error("stalled result changed");
endmodule

bind hsv_to_rgb_percent_top hsv2rgb_checker u_hsv2rgb_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_red(rsp.red),
   .rsp_green(rsp.green),
   .rsp_blue(rsp.blue)
);
